### rtl/servo_leg_home_pose_defines.svh
// Assertion helpers used by servo_leg_home_pose.
`ifndef SERVO_LEG_HOME_POSE_DEFINES_SVH
`define SERVO_LEG_HOME_POSE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SLHP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slhp assertion failed");

// Next-cycle implication, disabled in reset.
`define SLHP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slhp assertion failed");

`endif

### rtl/slhp_pkg.sv
`default_nettype none
package slhp_pkg;

    localparam int ROT_STEPS = 20;
    localparam int VEC_STEPS = 20;
    localparam int Z_W       = 32;

    localparam logic signed [32:0] GAIN_Q30  = 33'sd652032874;
    localparam int                 COORD_LIM = 65535;
    localparam int                 ANGLE_LIM = 25736;

    localparam logic [15:0] LEG_RESET = 16'd32768;
    localparam logic [15:0] ARM_RESET = 16'd4096;

    // Configuration register indexes
    localparam int   CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NEG_RAD    = 2'd1,
        ST_ASIN_RANGE = 2'd2,
        ST_ZERO_DEN   = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [16:0] py;
        logic signed [16:0] px;
        logic signed [16:0] by;
        logic signed [16:0] bx;
    } coord_t;

    typedef struct packed {
        coord_t             coord;
        logic signed [17:0] dx;
        logic [15:0]        arm;
        logic [31:0]        arm2;
        logic               neg;
    } sq1_side_t;

    typedef struct packed {
        coord_t             coord;
        logic signed [17:0] dx;
        logic [15:0]        arm;
        logic [16:0]        h0;
        status_t            status;
    } sq2_side_t;

    typedef struct packed {
        coord_t      coord;
        logic [15:0] height;
        status_t     status;
    } vec_side_t;

    // atan(2^-i) in hundredths of a degree times 2^16
    function automatic logic signed [Z_W-1:0] deg_tab(input int unsigned i);
        case (i)
            0:       return 32'sd294912000;
            1:       return 32'sd174096719;
            2:       return 32'sd91987925;
            3:       return 32'sd46694507;
            4:       return 32'sd23437865;
            5:       return 32'sd11730358;
            6:       return 32'sd5866610;
            7:       return 32'sd2933484;
            8:       return 32'sd1466765;
            9:       return 32'sd733385;
            10:      return 32'sd366693;
            11:      return 32'sd183346;
            12:      return 32'sd91673;
            13:      return 32'sd45837;
            14:      return 32'sd22918;
            15:      return 32'sd11459;
            16:      return 32'sd5730;
            17:      return 32'sd2865;
            18:      return 32'sd1432;
            19:      return 32'sd716;
            default: return '0;
        endcase
    endfunction

    // atan(2^-i) in radians, Q4.28
    function automatic logic signed [Z_W-1:0] rad_tab(input int unsigned i);
        case (i)
            0:       return 32'sd210828714;
            1:       return 32'sd124459457;
            2:       return 32'sd65760959;
            3:       return 32'sd33381290;
            4:       return 32'sd16755422;
            5:       return 32'sd8385879;
            6:       return 32'sd4193963;
            7:       return 32'sd2097109;
            8:       return 32'sd1048571;
            9:       return 32'sd524287;
            10:      return 32'sd262144;
            11:      return 32'sd131072;
            12:      return 32'sd65536;
            13:      return 32'sd32768;
            14:      return 32'sd16384;
            15:      return 32'sd8192;
            16:      return 32'sd4096;
            17:      return 32'sd2048;
            18:      return 32'sd1024;
            19:      return 32'sd512;
            default: return '0;
        endcase
    endfunction

    // Round a Q2.30-scaled product back to Q8.8 and clamp
    function automatic logic signed [16:0] round_coord(input logic signed [49:0] p);
        logic signed [49:0] q;
        q = (p + 50'sd536870912) >>> 30;
        if (q > 50'sd65535)
            return 17'sd65535;
        else if (q < -50'sd65535)
            return -17'sd65535;
        else
            return q[16:0];
    endfunction

endpackage
`default_nettype wire

### rtl/servo_leg_home_pose.sv
`default_nettype none
`include "servo_leg_home_pose_defines.svh"
// Home pose of one servo leg of a six-leg motion platform. Each input word carries the
// polar base and platform anchors (radius Q8.8 mm, bearing in hundredths of a degree);
// each output word carries both anchors in x/y (Q8.8 mm), the home platform height
// (Q8.8 mm, saturated) and the servo rest angle (Q3.13 rad), plus a status code. Any
// nonzero status (negative radicand, zero denominator, asin argument above one) zeroes
// all value fields. The block takes one word per clock unless the pipe is halted; its
// stages are: input register, 20 rotation CORDIC stages, multiply and round (2),
// difference squares and radicand (2), a 17-stage square root, rounding and height
// checks (3), a 30-stage square root and 20 vectoring CORDIC stages, then the output
// register. A one-word skid buffer behind the output register keeps the input open
// while a result waits; the pipe only halts once both hold a word. Leg and arm lengths
// are written through the cfg port; the user must write them while the block is idle,
// as the block itself does not enforce it.
module servo_leg_home_pose (
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata: base_radius, base_bearing, platform_radius, platform_bearing
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [63:0]                       s_tdata,
    // m_tdata: base_x, base_y, platform_x, platform_y, home_height,
    //          rest_angle, status, 2 zero pad bits
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [103:0]                      m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [slhp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [15:0]                       cfg_data
);
    import slhp_pkg::*;

    localparam int SQ1_RAD_W = 34;
    localparam int SQ2_RAD_W = 60;
    localparam int VEC_W     = 41;

    // ---------------------------------------------------------------- config
    logic [15:0] leg_reg;
    logic [15:0] arm_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leg_reg <= LEG_RESET;
            arm_reg <= ARM_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LEG: leg_reg <= cfg_data;
                CFG_ARM: arm_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------- stall control
    // The whole pipe advances together; it halts only when the skid word is full.
    logic en;
    logic skid_valid_reg;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ---------------------------------------------------- rotation CORDIC
    // Lane 0 is the base anchor, lane 1 the platform anchor.
    logic signed [32:0]    rx_reg [0:ROT_STEPS][0:1];
    logic signed [32:0]    ry_reg [0:ROT_STEPS][0:1];
    logic signed [Z_W-1:0] rz_reg [0:ROT_STEPS][0:1];
    logic                  rf_reg [0:ROT_STEPS][0:1];
    logic [15:0]           rr_reg [0:ROT_STEPS][0:1];
    logic                  rv_reg [0:ROT_STEPS];

    logic [15:0] lane_r [2];
    logic [15:0] lane_b [2];
    assign lane_r[0] = s_tdata[15:0];
    assign lane_b[0] = s_tdata[31:16];
    assign lane_r[1] = s_tdata[47:32];
    assign lane_b[1] = s_tdata[63:48];

    for (genvar l = 0; l < 2; l++) begin : g_in
        logic [15:0]        bm;
        logic signed [16:0] t;
        logic               fl;

        // Fold the bearing into +-90 degrees; the back half flips the result.
        always_comb
        begin
            bm = (lane_b[l] >= 16'd36000) ? lane_b[l] - 16'd36000 : lane_b[l];
            fl = 1'b0;
            if (bm > 16'd27000)
                t = signed'({1'b0, bm}) - 17'sd36000;
            else if (bm > 16'd9000)
            begin
                t  = signed'({1'b0, bm}) - 17'sd18000;
                fl = 1'b1;
            end
            else
                t = signed'({1'b0, bm});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[0][l] <= GAIN_Q30;
                ry_reg[0][l] <= '0;
                rz_reg[0][l] <= Z_W'(t) <<< 16;
                rf_reg[0][l] <= fl;
                rr_reg[0][l] <= lane_r[l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg[0] <= 1'b0;
        else if (en)
            rv_reg[0] <= s_tvalid;
    end

    for (genvar i = 0; i < ROT_STEPS; i++) begin : g_rot
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic signed [32:0] sx, sy;
            assign sx = ry_reg[i][l] >>> i;
            assign sy = rx_reg[i][l] >>> i;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!rz_reg[i][l][Z_W-1])
                    begin
                        rx_reg[i+1][l] <= rx_reg[i][l] - sx;
                        ry_reg[i+1][l] <= ry_reg[i][l] + sy;
                        rz_reg[i+1][l] <= rz_reg[i][l] - deg_tab(i);
                    end
                    else
                    begin
                        rx_reg[i+1][l] <= rx_reg[i][l] + sx;
                        ry_reg[i+1][l] <= ry_reg[i][l] - sy;
                        rz_reg[i+1][l] <= rz_reg[i][l] + deg_tab(i);
                    end
                    rf_reg[i+1][l] <= rf_reg[i][l];
                    rr_reg[i+1][l] <= rr_reg[i][l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rv_reg[i+1] <= 1'b0;
            else if (en)
                rv_reg[i+1] <= rv_reg[i];
        end
    end

    // ------------------------------------------ scale by radius, then round
    // pm_reg[l][0] is r*sin (x), pm_reg[l][1] is r*cos (y)
    logic signed [49:0] pm_reg [0:1][0:1];
    logic               pv_reg;

    for (genvar l = 0; l < 2; l++) begin : g_mul
        logic signed [32:0] xf, yf;
        assign xf = rf_reg[ROT_STEPS][l] ? -rx_reg[ROT_STEPS][l] : rx_reg[ROT_STEPS][l];
        assign yf = rf_reg[ROT_STEPS][l] ? -ry_reg[ROT_STEPS][l] : ry_reg[ROT_STEPS][l];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pm_reg[l][0] <= signed'({1'b0, rr_reg[ROT_STEPS][l]}) * yf;
                pm_reg[l][1] <= signed'({1'b0, rr_reg[ROT_STEPS][l]}) * xf;
            end
        end
    end

    coord_t cc_reg;
    logic   cv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cc_reg.bx <= round_coord(pm_reg[0][0]);
            cc_reg.by <= round_coord(pm_reg[0][1]);
            cc_reg.px <= round_coord(pm_reg[1][0]);
            cc_reg.py <= round_coord(pm_reg[1][1]);
        end
    end

    // ----------------------------------------------- squares and radicand
    logic signed [17:0] dx, dy;
    logic signed [35:0] dxsq, dysq;
    assign dx   = 18'(cc_reg.px) - 18'(cc_reg.bx);
    assign dy   = 18'(cc_reg.py) - 18'(cc_reg.by);
    assign dxsq = dx * dx;
    assign dysq = dy * dy;

    coord_t             dc_reg;
    logic signed [17:0] ddx_reg;
    logic [33:0]        ddx2_reg, ddy2_reg;
    logic [31:0]        dlg2_reg, da2_reg;
    logic [15:0]        da_reg;
    logic               dv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dc_reg   <= cc_reg;
            ddx_reg  <= dx;
            ddx2_reg <= dxsq[33:0];
            ddy2_reg <= dysq[33:0];
            dlg2_reg <= leg_reg * leg_reg;
            da2_reg  <= arm_reg * arm_reg;
            da_reg   <= arm_reg;
        end
    end

    logic signed [36:0] rad;
    assign rad = signed'({5'b0, dlg2_reg}) + signed'({5'b0, da2_reg})
               - signed'({3'b0, ddx2_reg}) - signed'({3'b0, ddy2_reg});

    logic [SQ1_RAD_W-1:0] erad_reg;
    sq1_side_t            eside_reg;
    logic                 ev_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            erad_reg        <= rad[36] ? '0 : rad[SQ1_RAD_W-1:0];
            eside_reg.coord <= dc_reg;
            eside_reg.dx    <= ddx_reg;
            eside_reg.arm   <= da_reg;
            eside_reg.arm2  <= da2_reg;
            eside_reg.neg   <= rad[36];
        end
    end

    // ---------------------------------------------- home height square root
    logic                   s1v;
    logic [SQ1_RAD_W/2-1:0] s1root;
    logic [SQ1_RAD_W/2:0]   s1rem;
    sq1_side_t              s1side;

    slhp_sqrt_pipe #(
        .RAD_W  (SQ1_RAD_W),
        .SIDE_W ($bits(sq1_side_t))
    ) u_sqrt_h0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ev_reg),
        .in_rad    (erad_reg),
        .in_side   (eside_reg),
        .out_valid (s1v),
        .root      (s1root),
        .rem       (s1rem),
        .out_side  (s1side)
    );

    // Round to nearest: bump when the remainder passes the root
    logic [16:0] fh0_reg;
    sq1_side_t   fside_reg;
    logic        fv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fh0_reg   <= s1root + 17'((s1rem > {1'b0, s1root}) ? 1 : 0);
            fside_reg <= s1side;
        end
    end

    logic signed [35:0] gdxsq;
    assign gdxsq = fside_reg.dx * fside_reg.dx;

    logic [16:0] gh0_reg;
    logic [33:0] gh0sq_reg, gdx2_reg;
    sq1_side_t   gside_reg;
    logic        gv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gh0_reg   <= fh0_reg;
            gh0sq_reg <= fh0_reg * fh0_reg;
            gdx2_reg  <= gdxsq[33:0];
            gside_reg <= fside_reg;
        end
    end

    // ---------------------------------------------------- status decision
    logic [34:0] dsum, ddiff;
    status_t     st;
    assign dsum  = {1'b0, gdx2_reg} + {1'b0, gh0sq_reg};
    assign ddiff = dsum - {3'b0, gside_reg.arm2};

    always_comb
    begin
        if (gside_reg.neg)
            st = ST_NEG_RAD;
        else if (gside_reg.arm == '0 || gh0_reg == '0)
            st = ST_ZERO_DEN;
        else if ({3'b0, gside_reg.arm2} > dsum)
            st = ST_ASIN_RANGE;
        else
            st = ST_OK;
    end

    logic [SQ2_RAD_W-1:0] hrad_reg;
    sq2_side_t            hside_reg;
    logic                 hv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hrad_reg         <= {1'b0, ddiff, 24'b0};
            hside_reg.coord  <= gside_reg.coord;
            hside_reg.dx     <= gside_reg.dx;
            hside_reg.arm    <= gside_reg.arm;
            hside_reg.h0     <= gh0_reg;
            hside_reg.status <= st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
            cv_reg <= 1'b0;
            dv_reg <= 1'b0;
            ev_reg <= 1'b0;
            fv_reg <= 1'b0;
            gv_reg <= 1'b0;
            hv_reg <= 1'b0;
        end
        else if (en)
        begin
            pv_reg <= rv_reg[ROT_STEPS];
            cv_reg <= pv_reg;
            dv_reg <= cv_reg;
            ev_reg <= dv_reg;
            fv_reg <= s1v;
            gv_reg <= fv_reg;
            hv_reg <= gv_reg;
        end
    end

    // ------------------------------------------ asin leg: sqrt(d - a^2)
    logic                   s2v;
    logic [SQ2_RAD_W/2-1:0] s2root;
    sq2_side_t              s2side;

    slhp_sqrt_pipe #(
        .RAD_W  (SQ2_RAD_W),
        .SIDE_W ($bits(sq2_side_t))
    ) u_sqrt_w (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (hv_reg),
        .in_rad    (hrad_reg),
        .in_side   (hside_reg),
        .out_valid (s2v),
        .root      (s2root),
        .rem       (),
        .out_side  (s2side)
    );

    // ---------------------------------------------- two vectoring CORDICs
    // Lane 0: atan2(a, w) gives the asin term; lane 1: atan2(dx, h0).
    logic signed [VEC_W-1:0] vx_in [2];
    logic signed [VEC_W-1:0] vy_in [2];
    vec_side_t               vin_side;

    assign vx_in[0] = VEC_W'(s2root);
    assign vy_in[0] = VEC_W'({s2side.arm, 12'b0});
    assign vx_in[1] = VEC_W'({s2side.h0, 20'b0});
    assign vy_in[1] = VEC_W'(signed'({s2side.dx, 20'b0}));

    assign vin_side.coord  = s2side.coord;
    assign vin_side.height = s2side.h0[16] ? 16'hFFFF : s2side.h0[15:0];
    assign vin_side.status = s2side.status;

    logic                  vv;
    logic signed [Z_W-1:0] vz [2];
    vec_side_t             vside;

    slhp_vec_pipe #(
        .W      (VEC_W),
        .SIDE_W ($bits(vec_side_t))
    ) u_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2v),
        .in_x      (vx_in),
        .in_y      (vy_in),
        .in_side   (vin_side),
        .out_valid (vv),
        .out_z     (vz),
        .out_side  (vside)
    );

    // ------------------------------------------------ final angle and word
    logic signed [Z_W:0] ang_sum, ang_sh;
    logic signed [15:0]  angle;
    logic [103:0]        res_data;

    assign ang_sum = (Z_W+1)'(vz[0]) - (Z_W+1)'(vz[1]) + (Z_W+1)'(16384);
    assign ang_sh  = ang_sum >>> 15;

    always_comb
    begin
        if (ang_sh > (Z_W+1)'(ANGLE_LIM))
            angle = 16'(ANGLE_LIM);
        else if (ang_sh < -(Z_W+1)'(ANGLE_LIM))
            angle = -16'(ANGLE_LIM);
        else
            angle = ang_sh[15:0];

        if (vside.status != ST_OK)
            res_data = {2'b0, vside.status, 100'b0};
        else
            res_data = {2'b0, vside.status, angle, vside.height, vside.coord.py,
                        vside.coord.px, vside.coord.by, vside.coord.bx};
    end

    // ------------------------------------------ output register and skid
    logic         out_valid_reg, out_valid_next;
    logic [103:0] out_data_reg, out_data_next;
    logic         skid_valid_next;
    logic [103:0] skid_data_reg, skid_data_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready)
        begin
            // Output slot frees up: drain the skid word first
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = vv;
                out_data_next  = res_data;
            end
        end
        else if (vv && en)
        begin
            // Output held: park the emerging word
            skid_valid_next = 1'b1;
            skid_data_next  = res_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------ checks
    `SLHP_ASSERT_IMP(a_skid_needs_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `SLHP_ASSERT_IMP(a_err_zero, clk, rst_n, m_tvalid && (m_tdata[101:100] != ST_OK), m_tdata[99:0] == '0)
    `SLHP_ASSERT_NXT(a_skid_hold, clk, rst_n, skid_valid_reg && !m_tready, skid_valid_reg && $stable(skid_data_reg))

endmodule
`default_nettype wire

### rtl/slhp_sqrt_pipe.sv
`default_nettype none
module slhp_sqrt_pipe #(
    parameter int RAD_W  = 34,
    parameter int SIDE_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [RAD_W-1:0]     in_rad,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic [RAD_W/2-1:0]   root,
    output logic [RAD_W/2:0]     rem,
    output logic [SIDE_W-1:0]    out_side
);
    localparam int ROOT_W = RAD_W / 2;

    logic [ROOT_W:0]   rem_reg  [1:ROOT_W];
    logic [ROOT_W-1:0] root_reg [1:ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [1:ROOT_W];
    logic [SIDE_W-1:0] side_reg [1:ROOT_W];
    logic              vld_reg  [1:ROOT_W];

    // One result bit per stage, two radicand bits consumed per stage
    for (genvar k = 0; k < ROOT_W; k++) begin : g_stg
        logic [ROOT_W:0]   rem_i;
        logic [ROOT_W-1:0] root_i;
        logic [RAD_W-1:0]  rad_i;
        logic [SIDE_W-1:0] side_i;
        logic              vld_i;
        logic [ROOT_W+2:0] rem_t;
        logic [ROOT_W+2:0] trial;

        if (k == 0) begin : g_first
            assign rem_i  = '0;
            assign root_i = '0;
            assign rad_i  = in_rad;
            assign side_i = in_side;
            assign vld_i  = in_valid;
        end
        else begin : g_next
            assign rem_i  = rem_reg[k];
            assign root_i = root_reg[k];
            assign rad_i  = rad_reg[k];
            assign side_i = side_reg[k];
            assign vld_i  = vld_reg[k];
        end

        assign rem_t = {rem_i, rad_i[RAD_W-1 -: 2]};
        assign trial = {1'b0, root_i, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_t >= trial)
                begin
                    rem_reg[k+1]  <= (ROOT_W+1)'(rem_t - trial);
                    root_reg[k+1] <= {root_i[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1]  <= rem_t[ROOT_W:0];
                    root_reg[k+1] <= {root_i[ROOT_W-2:0], 1'b0};
                end
                rad_reg[k+1]  <= rad_i << 2;
                side_reg[k+1] <= side_i;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_i;
        end
    end

    assign out_valid = vld_reg[ROOT_W];
    assign root      = root_reg[ROOT_W];
    assign rem       = rem_reg[ROOT_W];
    assign out_side  = side_reg[ROOT_W];

endmodule
`default_nettype wire

### rtl/slhp_vec_pipe.sv
`default_nettype none
module slhp_vec_pipe #(
    parameter int W      = 41,
    parameter int SIDE_W = 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [W-1:0]              in_x [2],
    input  logic signed [W-1:0]              in_y [2],
    input  logic [SIDE_W-1:0]                in_side,
    output logic                             out_valid,
    output logic signed [slhp_pkg::Z_W-1:0]  out_z [2],
    output logic [SIDE_W-1:0]                out_side
);
    import slhp_pkg::*;

    logic signed [W-1:0]   x_reg    [1:VEC_STEPS][0:1];
    logic signed [W-1:0]   y_reg    [1:VEC_STEPS][0:1];
    logic signed [Z_W-1:0] z_reg    [1:VEC_STEPS][0:1];
    logic [SIDE_W-1:0]     side_reg [1:VEC_STEPS];
    logic                  vld_reg  [1:VEC_STEPS];

    // Two vectoring lanes side by side, one micro-rotation per stage
    for (genvar k = 0; k < VEC_STEPS; k++) begin : g_stg
        logic [SIDE_W-1:0] side_i;
        logic              vld_i;

        if (k == 0) begin : g_first
            assign side_i = in_side;
            assign vld_i  = in_valid;
        end
        else begin : g_next
            assign side_i = side_reg[k];
            assign vld_i  = vld_reg[k];
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic signed [W-1:0]   x_i, y_i, sx, sy;
            logic signed [Z_W-1:0] z_i;

            if (k == 0) begin : g_first
                assign x_i = in_x[l];
                assign y_i = in_y[l];
                assign z_i = '0;
            end
            else begin : g_next
                assign x_i = x_reg[k][l];
                assign y_i = y_reg[k][l];
                assign z_i = z_reg[k][l];
            end

            assign sx = y_i >>> k;
            assign sy = x_i >>> k;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!y_i[W-1])
                    begin
                        x_reg[k+1][l] <= x_i + sx;
                        y_reg[k+1][l] <= y_i - sy;
                        z_reg[k+1][l] <= z_i + rad_tab(k);
                    end
                    else
                    begin
                        x_reg[k+1][l] <= x_i - sx;
                        y_reg[k+1][l] <= y_i + sy;
                        z_reg[k+1][l] <= z_i - rad_tab(k);
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                side_reg[k+1] <= side_i;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_i;
        end
    end

    assign out_valid = vld_reg[VEC_STEPS];
    assign out_z[0]  = z_reg[VEC_STEPS][0];
    assign out_z[1]  = z_reg[VEC_STEPS][1];
    assign out_side  = side_reg[VEC_STEPS];

endmodule
`default_nettype wire

### tb/sv/servo_leg_home_pose_checker.sv
`timescale 1ns / 1ps
// Watches the input, output and cfg channels of servo_leg_home_pose, computes the
// expected home pose of every accepted input word and compares it with the output.
module servo_leg_home_pose_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [63:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [slhp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]  cfg_data,
    output int           errors,
    output int           pending,
    output int           results_seen,
    output int           faults_seen
);
    import slhp_pkg::*;

    typedef struct packed {
        logic signed [16:0] bx;
        logic signed [16:0] by;
        logic signed [16:0] px;
        logic signed [16:0] py;
        logic [15:0]        height;
        logic signed [15:0] angle;
        status_t            status;
    } pose_t;

    localparam longint DEG_ATAN [20] = '{
        294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
        5866610, 2933484, 1466765, 733385, 366693, 183346, 91673,
        45837, 22918, 11459, 5730, 2865, 1432, 716};
    localparam longint RAD_ATAN [20] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072, 65536,
        32768, 16384, 8192, 4096, 2048, 1024, 512};

    logic [15:0] leg_q88;
    logic [15:0] arm_q88;
    pose_t       pose_q[$];

    function automatic longint sat(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Rotate the gain-corrected unit vector to the bearing, scale by the radius.
    function automatic void anchor_xy(input longint r, input longint bearing,
                                      output longint ox, output longint oy);
        longint t, x, y, z, sx, sy;
        bit     flip;
        t = bearing % 36000;
        flip = 0;
        x = 652032874;
        y = 0;
        if (t > 27000)
            t = t - 36000;
        else if (t > 9000)
        begin
            t = t - 18000;
            flip = 1;
        end
        z = t * 65536;
        for (int i = 0; i < 20; i++)
        begin
            sx = y >>> i;
            sy = x >>> i;
            if (z >= 0)
            begin
                x = x - sx; y = y + sy; z = z - DEG_ATAN[i];
            end
            else
            begin
                x = x + sx; y = y - sy; z = z + DEG_ATAN[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        ox = sat((r * y + (64'sd1 <<< 29)) >>> 30, 65535);
        oy = sat((r * x + (64'sd1 <<< 29)) >>> 30, 65535);
    endfunction

    function automatic longint atan2_pos(input longint x, input longint y);
        longint z, sx, sy;
        z = 0;
        for (int i = 0; i < 20; i++)
        begin
            sx = y >>> i;
            sy = x >>> i;
            if (y >= 0)
            begin
                x = x + sx; y = y - sy; z = z + RAD_ATAN[i];
            end
            else
            begin
                x = x - sx; y = y + sy; z = z - RAD_ATAN[i];
            end
        end
        return z;
    endfunction

    function automatic pose_t home_pose(input logic [63:0] w);
        longint  bx, by, px, py, dx, dy, a, lg, rad, h0, d, root, as, at, ang;
        longint unsigned s;
        pose_t   p;
        anchor_xy(longint'(w[15:0]), longint'(w[31:16]), bx, by);
        anchor_xy(longint'(w[47:32]), longint'(w[63:48]), px, py);
        dx = px - bx;
        dy = py - by;
        a  = longint'(arm_q88);
        lg = longint'(leg_q88);
        rad = lg * lg + a * a - dx * dx - dy * dy;
        h0 = 0;
        ang = 0;
        p = '0;
        if (rad < 0)
            p.status = ST_NEG_RAD;
        else
        begin
            s = int_sqrt(longint'(rad));
            if (longint'(rad) - s * s > s) s = s + 1;
            h0 = longint'(s);
            if (a == 0 || h0 == 0)
                p.status = ST_ZERO_DEN;
            else
            begin
                d = dx * dx + h0 * h0;
                if (a * a > d)
                    p.status = ST_ASIN_RANGE;
                else
                begin
                    root = longint'(int_sqrt(longint'(d - a * a) << 24));
                    as = atan2_pos(root, a * 4096);
                    at = atan2_pos(h0 * 1048576, dx * 1048576);
                    ang = sat((as - at + (64'sd1 <<< 14)) >>> 15, 25736);
                    p.status = ST_OK;
                end
            end
        end
        if (p.status == ST_OK)
        begin
            p.bx = bx[16:0];
            p.by = by[16:0];
            p.px = px[16:0];
            p.py = py[16:0];
            p.height = (h0 > 65535) ? 16'hFFFF : h0[15:0];
            p.angle = ang[15:0];
        end
        return p;
    endfunction

    assign pending = pose_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        pose_t want, got;
        if (!rst_n)
        begin
            leg_q88 <= LEG_RESET;
            arm_q88 <= ARM_RESET;
            errors = 0;
            results_seen = 0;
            faults_seen = 0;
            pose_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_LEG) leg_q88 <= cfg_data;
                if (cfg_index == CFG_ARM) arm_q88 <= cfg_data;
            end
            if (s_tvalid && s_tready)
                pose_q.push_back(home_pose(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got.bx     = m_tdata[16:0];
                got.by     = m_tdata[33:17];
                got.px     = m_tdata[50:34];
                got.py     = m_tdata[67:51];
                got.height = m_tdata[83:68];
                got.angle  = m_tdata[99:84];
                got.status = status_t'(m_tdata[101:100]);
                results_seen++;
                if (got.status != ST_OK) faults_seen++;
                if (pose_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected output word %h", $time, m_tdata);
                end
                else
                begin
                    want = pose_q.pop_front();
                    if (got != want)
                    begin
                        errors++;
                        $display("%0t: expected bx %0d by %0d px %0d py %0d h %0d ang %0d st %0d",
                                 $time, want.bx, want.by, want.px, want.py,
                                 want.height, want.angle, want.status);
                        $display("%0t: actual   bx %0d by %0d px %0d py %0d h %0d ang %0d st %0d",
                                 $time, got.bx, got.by, got.px, got.py,
                                 got.height, got.angle, got.status);
                    end
                end
            end
        end
    end
endmodule

### tb/sv/tb_servo_leg_home_pose.sv
`timescale 1ns / 1ps
// Stimulus and verdict for servo_leg_home_pose. The checker beside the block does
// all prediction; this module only drives words and decides pass or fail.
module tb_servo_leg_home_pose;
    import slhp_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;  // pipe latency plus long stalls, several times over
    localparam int DRAIN_CYCLES   = 150;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]  cfg_data;

    int errors, pending, results_seen, faults_seen;
    int idle_cycles;
    int words_sent;
    int cfg_writes;
    bit no_gaps;      // phase with back-to-back words on both sides
    int stall_left;

    servo_leg_home_pose uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    servo_leg_home_pose_checker pose_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen),
        .faults_seen  (faults_seen)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: hold tready low for random stretches, change only at falling edges.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            stall_left <= gap_len();
            m_tready <= 1'b1;
        end
    end

    // Watchdog: count cycles in which no channel moves a word.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Present one word, hold it until accepted, then idle for a random gap.
    task automatic send_leg(input logic [15:0] br, input logic [15:0] bb,
                            input logic [15:0] pr, input logic [15:0] pb);
        int g;
        s_tdata  = {pb, pr, bb, br};
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        words_sent++;
        @(negedge clk);
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid = 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Drain the pipe, then load a new leg/arm pair.
    task automatic set_geometry(input logic [15:0] leg, input logic [15:0] arm);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        write_reg(CFG_LEG, leg);
        write_reg(CFG_ARM, arm);
    endtask

    // Mostly nearby anchor pairs so the pose solves; the rest raw noise.
    task automatic random_leg(input logic [15:0] leg);
        int mode, br, pr, bb, pb, span;
        mode = $urandom_range(0, 9);
        if (mode <= 6)
        begin
            br = (mode < 3) ? $urandom_range(0, 65535) : $urandom_range(0, 4096);
            span = leg / 3 + 1;
            pr = br + $urandom_range(0, 2 * span) - span;
            if (pr < 0) pr = 0;
            if (pr > 65535) pr = 65535;
            bb = $urandom_range(0, 35999);
            pb = (bb + 36000 + $urandom_range(0, 600) - 300) % 36000;
            if (mode == 6)
            begin
                bb = bb + 36000;
                pb = pb + 36000;
            end
            send_leg(16'(br), 16'(bb), 16'(pr), 16'(pb));
        end
        else if (mode <= 8)
            send_leg(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else
            send_leg(16'($urandom_range(30000, 65535)), 16'($urandom_range(0, 35999)),
                     16'($urandom_range(30000, 65535)), 16'($urandom_range(0, 35999)));
    endtask

    initial
    begin
        logic [15:0] legs [8];
        logic [15:0] arms [8];
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_LEG;
        cfg_data   = '0;
        stall_left = 0;
        no_gaps    = 1'b0;
        words_sent = 0;
        cfg_writes = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed words at the reset geometry: axes, quadrant edges, wrap, extremes.
        send_leg(16'd0, 16'd0, 16'd0, 16'd0);
        send_leg(16'd65535, 16'd0, 16'd65535, 16'd18000);
        send_leg(16'd65535, 16'd9000, 16'd65535, 16'd9000);
        send_leg(16'd12800, 16'd9001, 16'd12800, 16'd9001);
        send_leg(16'd12800, 16'd18000, 16'd12900, 16'd18000);
        send_leg(16'd12800, 16'd27000, 16'd12800, 16'd27001);
        send_leg(16'd1000, 16'd35999, 16'd1000, 16'd35999);
        send_leg(16'd1000, 16'd36000, 16'd1200, 16'd36001);
        send_leg(16'd65535, 16'd65535, 16'd65535, 16'd65535);
        send_leg(16'd0, 16'd0, 16'd65535, 16'd0);
        send_leg(16'd5000, 16'd4500, 16'd5000, 16'd4600);
        send_leg(16'd40000, 16'd30000, 16'd40100, 16'd29950);

        // Zero arm: zero denominator.
        set_geometry(16'd32768, 16'd0);
        send_leg(16'd0, 16'd0, 16'd0, 16'd0);
        send_leg(16'd3000, 16'd1000, 16'd3000, 16'd1000);
        // Anchor offset past the leg length: asin out of range, then right at one.
        set_geometry(16'd256, 16'd4096);
        send_leg(16'd0, 16'd0, 16'd512, 16'd0);
        send_leg(16'd0, 16'd0, 16'd256, 16'd0);
        // Zero leg with zero arm: zero height.
        set_geometry(16'd0, 16'd0);
        send_leg(16'd0, 16'd0, 16'd0, 16'd0);
        // Both at full scale: saturated height.
        set_geometry(16'd65535, 16'd65535);
        send_leg(16'd0, 16'd0, 16'd0, 16'd0);
        send_leg(16'd65535, 16'd0, 16'd65535, 16'd100);

        legs = '{16'd32768, 16'd65535, 16'd0, 16'd20000, 16'd65535, 16'd5000,
                 16'd256, 16'd40000};
        arms = '{16'd4096, 16'd65535, 16'd65535, 16'd0, 16'd1, 16'd2000,
                 16'd4096, 16'd10000};
        for (int ph = 0; ph < 8; ph++)
        begin
            set_geometry(legs[ph], arms[ph]);
            no_gaps = (ph % 3 == 2);
            repeat (80) random_leg(legs[ph]);
        end
        no_gaps = 1'b0;
        s_tvalid = 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d leg words over 13 leg/arm settings (%0d register writes).",
                 words_sent, cfg_writes);
        $display("Checked %0d results, %0d of them with a fault status.",
                 results_seen, faults_seen);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
